>>> hw/rtl/apla_pkg.sv
// Shared types, constants and the arctangent table of the angular path length accumulator.
`default_nettype none

package apla_pkg;

    // Field widths.
    localparam int COMP_W  = 18;
    localparam int INC_W   = 21;
    localparam int TOTAL_W = 40;
    localparam int BAD_W   = 11;
    localparam int SUM_W   = 46;
    localparam int ANG_W   = 19;
    localparam int CNT_W   = 5;

    // Last step index of each iterative phase.
    localparam logic [CNT_W-1:0] MAC_LAST  = 5'd8;
    localparam logic [CNT_W-1:0] SQRT_LAST = 5'd31;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd29;
    localparam logic [CNT_W-1:0] COR_LAST  = 5'd29;

    localparam logic [30:0]        ONE_Q30 = 31'h4000_0000;
    localparam logic signed [34:0] PI_Q30  = 35'sd3373259426;
    localparam logic [BAD_W-1:0]   BAD_MAX = 11'd2047;
    localparam logic [INC_W-1:0]   INC_MAX = 21'h1F_FFFF;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAC,
        OP_SQA_INIT,
        OP_SQB_INIT,
        OP_SQ_STEP,
        OP_DEN,
        OP_DIV_INIT,
        OP_ONE,
        OP_DIV_STEP,
        OP_SQS_INIT,
        OP_COR_INIT,
        OP_COR_STEP,
        OP_ANG,
        OP_ACC,
        OP_SQI_INIT,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAC,
        S_SQA_INIT,
        S_SQA,
        S_SQB_INIT,
        S_SQB,
        S_DEN,
        S_DIV_INIT,
        S_ONE,
        S_DIV,
        S_SQS_INIT,
        S_SQS,
        S_COR_INIT,
        S_COR,
        S_ANG,
        S_ACC,
        S_SQI_INIT,
        S_SQI,
        S_OUT
    } state_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic eq;
        logic zero_norm;
        logic num_ge_den;
        logic last;
        logic out_busy;
    } dp_status_t;

    // atan(2^-i) in Q2.30.
    function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/apla_ctrl.sv
// Sequencing state machine of the angular path length accumulator.
`default_nettype none

module apla_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  apla_pkg::dp_status_t status,
    output apla_pkg::dp_cmd_t    cmd
);
    import apla_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_MAC;
            S_MAC:      if (cnt_reg == MAC_LAST) state_next = S_SQA_INIT;
            S_SQA_INIT: state_next = (status.eq || status.zero_norm) ? S_ANG : S_SQA;
            S_SQA:      if (cnt_reg == SQRT_LAST) state_next = S_SQB_INIT;
            S_SQB_INIT: state_next = S_SQB;
            S_SQB:      if (cnt_reg == SQRT_LAST) state_next = S_DEN;
            S_DEN:      state_next = S_DIV_INIT;
            S_DIV_INIT: state_next = status.num_ge_den ? S_ONE : S_DIV;
            S_ONE:      state_next = S_SQS_INIT;
            S_DIV:      if (cnt_reg == DIV_LAST) state_next = S_SQS_INIT;
            S_SQS_INIT: state_next = S_SQS;
            S_SQS:      if (cnt_reg == SQRT_LAST) state_next = S_COR_INIT;
            S_COR_INIT: state_next = S_COR;
            S_COR:      if (cnt_reg == COR_LAST) state_next = S_ANG;
            S_ANG:      state_next = S_ACC;
            S_ACC:      state_next = status.last ? S_SQI_INIT : S_IDLE;
            S_SQI_INIT: state_next = S_SQI;
            S_SQI:      if (cnt_reg == SQRT_LAST) state_next = S_OUT;
            S_OUT:      if (!status.out_busy) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
        // The step counter runs while a state repeats and restarts on every change.
        cnt_next = (state_next == state_reg) ? cnt_reg + 5'd1 : '0;
    end

    always_comb begin
        s_tready = 1'b0;
        cmd.cnt  = cnt_reg;
        cmd.op   = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.op   = s_tvalid ? OP_LOAD : OP_NONE;
            end
            S_MAC:      cmd.op = OP_MAC;
            S_SQA_INIT: cmd.op = OP_SQA_INIT;
            S_SQA:      cmd.op = OP_SQ_STEP;
            S_SQB_INIT: cmd.op = OP_SQB_INIT;
            S_SQB:      cmd.op = OP_SQ_STEP;
            S_DEN:      cmd.op = OP_DEN;
            S_DIV_INIT: cmd.op = OP_DIV_INIT;
            S_ONE:      cmd.op = OP_ONE;
            S_DIV:      cmd.op = OP_DIV_STEP;
            S_SQS_INIT: cmd.op = OP_SQS_INIT;
            S_SQS:      cmd.op = OP_SQ_STEP;
            S_COR_INIT: cmd.op = OP_COR_INIT;
            S_COR:      cmd.op = OP_COR_STEP;
            S_ANG:      cmd.op = OP_ANG;
            S_ACC:      cmd.op = OP_ACC;
            S_SQI_INIT: cmd.op = OP_SQI_INIT;
            S_SQI:      cmd.op = OP_SQ_STEP;
            S_OUT:      cmd.op = status.out_busy ? OP_NONE : OP_OUT;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/apla_dp.sv
// Datapath of the angular path length accumulator: shared multiplier, root, divider, CORDIC.
`default_nettype none

module apla_dp (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire  [111:0]         s_tdata,
    input  wire                  s_tlast,
    input  apla_pkg::dp_cmd_t    cmd,
    output apla_pkg::dp_status_t status,
    input  wire                  m_tready,
    output logic                 m_tvalid,
    output logic [71:0]          m_tdata
);
    import apla_pkg::*;

    logic signed [COMP_W-1:0] ox_reg, oy_reg, oz_reg, nx_reg, ny_reg, nz_reg;
    logic signed [COMP_W-1:0] ox_next, oy_next, oz_next, nx_next, ny_next, nz_next;
    logic               eq_reg, eq_next, last_reg, last_next;
    logic signed [37:0] dot_reg, dot_next;
    logic [35:0]        na2_reg, na2_next, nb2_reg, nb2_next;
    logic [63:0]        rad_reg, rad_next;
    logic [33:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next, na_reg, na_next;
    logic [61:0]        den_reg, den_next, drem_reg, drem_next;
    logic [30:0]        q_reg, q_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [ANG_W-1:0]   ang_reg, ang_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [BAD_W-1:0]   bad_reg, bad_next, out_bad_reg, out_bad_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [INC_W-1:0]   out_inc_reg, out_inc_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [37:0]        mag;
    logic [61:0]        num;
    logic [35:0]        rem_t, trial;
    logic [62:0]        d2;
    logic signed [33:0] xs, ys, atan_s;
    logic signed [34:0] zf;
    logic [46:0]        sum_w;
    logic [40:0]        tot_w;
    logic [INC_W-1:0]   inc;

    assign mag = dot_reg[37] ? 38'(-dot_reg) : 38'(dot_reg);
    assign num = {mag[35:0], 26'd0};

    assign status.eq         = eq_reg;
    assign status.zero_norm  = (na2_reg == '0) || (nb2_reg == '0);
    assign status.num_ge_den = (num >= den_reg);
    assign status.last       = last_reg;
    assign status.out_busy   = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_bad_reg, total_reg, out_inc_reg};

    // Operand selection for the one shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MAC: begin
                case (cmd.cnt)
                    5'd0:    begin mul_a = 33'(ox_reg); mul_b = 33'(nx_reg); end
                    5'd1:    begin mul_a = 33'(oy_reg); mul_b = 33'(ny_reg); end
                    5'd2:    begin mul_a = 33'(oz_reg); mul_b = 33'(nz_reg); end
                    5'd3:    begin mul_a = 33'(ox_reg); mul_b = 33'(ox_reg); end
                    5'd4:    begin mul_a = 33'(oy_reg); mul_b = 33'(oy_reg); end
                    5'd5:    begin mul_a = 33'(oz_reg); mul_b = 33'(oz_reg); end
                    5'd6:    begin mul_a = 33'(nx_reg); mul_b = 33'(nx_reg); end
                    5'd7:    begin mul_a = 33'(ny_reg); mul_b = 33'(ny_reg); end
                    default: begin mul_a = 33'(nz_reg); mul_b = 33'(nz_reg); end
                endcase
            end
            OP_DEN: begin
                mul_a = {1'b0, na_reg};
                mul_b = {1'b0, root_reg};
            end
            OP_SQS_INIT: begin
                mul_a = {2'b0, q_reg};
                mul_b = {2'b0, q_reg};
            end
            OP_ACC: begin
                mul_a = {14'd0, ang_reg};
                mul_b = {14'd0, ang_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        ox_next = ox_reg; oy_next = oy_reg; oz_next = oz_reg;
        nx_next = nx_reg; ny_next = ny_reg; nz_next = nz_reg;
        eq_next = eq_reg; last_next = last_reg;
        dot_next = dot_reg; na2_next = na2_reg; nb2_next = nb2_reg;
        rad_next = rad_reg; rem_next = rem_reg; root_next = root_reg; na_next = na_reg;
        den_next = den_reg; drem_next = drem_reg; q_next = q_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        ang_next = ang_reg; sum_next = sum_reg; bad_next = bad_reg;
        total_next = total_reg; out_inc_next = out_inc_reg; out_bad_next = out_bad_reg;
        m_tvalid_next = m_tvalid_reg;

        rem_t  = {rem_reg, rad_reg[63:62]};
        trial  = {2'b0, root_reg, 2'b01};
        d2     = {drem_reg, 1'b0};
        xs     = cx_reg >>> cmd.cnt;
        ys     = cy_reg >>> cmd.cnt;
        atan_s = {4'd0, atan_q30(cmd.cnt)};
        zf     = dot_reg[37] ? (PI_Q30 - 35'(cz_reg)) : 35'(cz_reg);
        sum_w  = {1'b0, sum_reg} + 47'(prod[37:0]);
        inc    = (root_reg > 32'(INC_MAX)) ? INC_MAX : root_reg[INC_W-1:0];
        tot_w  = {1'b0, total_reg} + 41'(inc);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (cmd.op)
            OP_LOAD: begin
                ox_next   = s_tdata[17:0];
                oy_next   = s_tdata[35:18];
                oz_next   = s_tdata[53:36];
                nx_next   = s_tdata[71:54];
                ny_next   = s_tdata[89:72];
                nz_next   = s_tdata[107:90];
                eq_next   = (s_tdata[53:0] == s_tdata[107:54]);
                last_next = s_tlast;
                dot_next  = '0;
                na2_next  = '0;
                nb2_next  = '0;
            end
            OP_MAC: begin
                if (cmd.cnt < 5'd3) begin
                    dot_next = dot_reg + prod[37:0];
                end else if (cmd.cnt < 5'd6) begin
                    na2_next = na2_reg + prod[35:0];
                end else begin
                    nb2_next = nb2_reg + prod[35:0];
                end
            end
            OP_SQA_INIT: begin
                rad_next  = {2'b0, na2_reg, 26'd0};
                rem_next  = '0;
                root_next = '0;
            end
            OP_SQB_INIT: begin
                na_next   = root_reg;
                rad_next  = {2'b0, nb2_reg, 26'd0};
                rem_next  = '0;
                root_next = '0;
            end
            OP_SQ_STEP: begin
                // One result bit per cycle, two radicand bits shifted in.
                if (rem_t >= trial) begin
                    rem_next  = 34'(rem_t - trial);
                    root_next = {root_reg[30:0], 1'b1};
                end else begin
                    rem_next  = rem_t[33:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
                rad_next = {rad_reg[61:0], 2'b00};
            end
            OP_DEN: begin
                den_next = prod[61:0];
            end
            OP_DIV_INIT: begin
                drem_next = num;
                q_next    = '0;
            end
            OP_ONE: begin
                q_next = ONE_Q30;
            end
            OP_DIV_STEP: begin
                if (d2 >= {1'b0, den_reg}) begin
                    drem_next = 62'(d2 - {1'b0, den_reg});
                    q_next    = {q_reg[29:0], 1'b1};
                end else begin
                    drem_next = d2[61:0];
                    q_next    = {q_reg[29:0], 1'b0};
                end
            end
            OP_SQS_INIT: begin
                rad_next  = 64'h1000_0000_0000_0000 - prod[63:0];
                rem_next  = '0;
                root_next = '0;
            end
            OP_COR_INIT: begin
                cx_next = {3'b0, q_reg};
                cy_next = {2'b0, root_reg};
                cz_next = '0;
            end
            OP_COR_STEP: begin
                if (cy_reg > 34'sd0) begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + atan_s;
                end else begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - atan_s;
                end
            end
            OP_ANG: begin
                if (eq_reg) begin
                    ang_next = '0;
                end else if (status.zero_norm) begin
                    ang_next = '0;
                    if (bad_reg != BAD_MAX) begin
                        bad_next = bad_reg + 11'd1;
                    end
                end else if (zf < 35'sd0) begin
                    ang_next = '0;
                end else begin
                    ang_next = ANG_W'((zf + 35'sd8192) >>> 14);
                end
            end
            OP_ACC: begin
                sum_next = sum_w[46] ? {SUM_W{1'b1}} : sum_w[45:0];
            end
            OP_SQI_INIT: begin
                rad_next  = {18'd0, sum_reg};
                rem_next  = '0;
                root_next = '0;
            end
            OP_OUT: begin
                total_next    = tot_w[40] ? {TOTAL_W{1'b1}} : tot_w[39:0];
                out_inc_next  = inc;
                out_bad_next  = bad_reg;
                m_tvalid_next = 1'b1;
                sum_next      = '0;
                bad_next      = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            bad_reg      <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            sum_reg      <= sum_next;
            bad_reg      <= bad_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg <= ox_next; oy_reg <= oy_next; oz_reg <= oz_next;
        nx_reg <= nx_next; ny_reg <= ny_next; nz_reg <= nz_next;
        eq_reg <= eq_next; last_reg <= last_next;
        dot_reg <= dot_next; na2_reg <= na2_next; nb2_reg <= nb2_next;
        rad_reg <= rad_next; rem_reg <= rem_next; root_reg <= root_next; na_reg <= na_next;
        den_reg <= den_next; drem_reg <= drem_next; q_reg <= q_next;
        cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
        ang_reg <= ang_next;
        out_inc_reg <= out_inc_next; out_bad_reg <= out_bad_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/angular_path_length_accumulator.sv
// Top level of the angular path length accumulator: controller plus datapath.
// An ordinary bond runs all of its phases from acceptance, but skips the divider when the cosine
// clamps to one; the bond marked last also takes the root of the step sum and the output.
// Throughput: one item at a time, set by the shared one-bit-per-cycle square root (three
// passes), the 30-step divider and the 30-step CORDIC; equal or zero vectors skip all three.
// Reset (aresetn low, synchronous) clears the step sum, bad count, running total and valid.
`default_nettype none

module angular_path_length_accumulator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // old_x[17:0], old_y[35:18], old_z[53:36], new_x[71:54], new_y[89:72],
    // new_z[107:90], zero fill [111:108]
    input  wire [111:0] s_tdata,
    // last_bond
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    // step_increment[20:0], total_length[60:21], bad_bonds[71:61]
    output logic [71:0] m_tdata
);
    import apla_pkg::*;

    // The controller walks the phases of one bond: products, the two norms, the
    // normalized cosine, its sine, the CORDIC arctangent, then the accumulation.
    // On a last item it adds the root of the step sum and posts one result item.
    dp_cmd_t    cmd;
    dp_status_t status;

    apla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The result sits in an output register, so a new item can be taken while the
    // previous result still waits; only the next post waits for that register.
    apla_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench of the angular path length accumulator, with its own bit-exact model.
`default_nettype none

module testbench;
    import apla_pkg::*;

    // Clock and reset.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #10 aclk = ~aclk;

    // Stream ports of the block under test.
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [71:0]  m_tdata;

    angular_path_length_accumulator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // One bond item and one step summary.
    typedef struct {
        logic signed [COMP_W-1:0] v[6];
        logic                     last;
    } bond_t;

    typedef struct {
        logic [INC_W-1:0]   inc;
        logic [TOTAL_W-1:0] total;
        logic [BAD_W-1:0]   bad;
    } step_sum_t;

    // The model's own copy of the block's state.
    logic [SUM_W-1:0]   mdl_sq_sum;
    logic [TOTAL_W-1:0] mdl_total;
    logic [BAD_W-1:0]   mdl_bad;

    // Step summaries that the block still owes, oldest first.
    step_sum_t pending_steps[$];

    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_recv = 1'b0;

    // Atan table in the same Q2.30 values as the block uses.
    localparam longint ATAN_TAB[30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149,
        1048575, 524287, 262143, 131071, 65535,
        32767, 16383, 8191, 4095, 2047,
        1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Angle between the old and new vectors in Q2.16; flags a zero-norm vector.
    function automatic longint unsigned bond_angle_q16(input bond_t b, output bit bad);
        longint a[3], n[3];
        longint dot, x, y, z, xs, ys;
        longint unsigned na2, nb2, den, mag, num, c, s, rem;
        bad = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a[i] = b.v[i];
            n[i] = b.v[i+3];
        end
        if (a[0] == n[0] && a[1] == n[1] && a[2] == n[2]) return 0;
        dot = a[0]*n[0] + a[1]*n[1] + a[2]*n[2];
        na2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        nb2 = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
        if (na2 == 0 || nb2 == 0) begin
            bad = 1'b1;
            return 0;
        end
        den = int_sqrt(na2 << 26) * int_sqrt(nb2 << 26);
        mag = (dot < 0) ? -dot : dot;
        num = mag << 26;
        if (num >= den) begin
            c = 64'd1 << 30;
        end else begin
            rem = num;
            c = 0;
            for (int i = 0; i < 30; i++) begin
                rem = rem << 1;
                c = c << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    c = c | 1;
                end
            end
        end
        s = int_sqrt((64'd1 << 60) - c*c);
        x = c;
        y = s;
        z = 0;
        for (int i = 0; i < 30; i++) begin
            // Arithmetic shifts floor, as the vectoring rotation requires.
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
        end
        if (dot < 0) z = 64'sd3373259426 - z;
        if (z < 0) z = 0;
        return (z + (1 << 13)) >> 14;
    endfunction

    // Advances the model by one bond; queues a summary on the last bond of a step.
    task automatic predict_bond(input bond_t b);
        longint unsigned ang, sum, inc, tot;
        bit bad;
        step_sum_t r;
        ang = bond_angle_q16(b, bad);
        if (bad && mdl_bad < BAD_MAX) mdl_bad = mdl_bad + 11'd1;
        sum = longint'(mdl_sq_sum) + ang*ang;
        if (sum > (64'd1 << SUM_W) - 1) sum = (64'd1 << SUM_W) - 1;
        mdl_sq_sum = SUM_W'(sum);
        if (b.last) begin
            inc = int_sqrt(sum);
            if (inc > INC_MAX) inc = INC_MAX;
            tot = longint'(mdl_total) + inc;
            if (tot > (64'd1 << TOTAL_W) - 1) tot = (64'd1 << TOTAL_W) - 1;
            mdl_total = TOTAL_W'(tot);
            r.inc = INC_W'(inc);
            r.total = TOTAL_W'(tot);
            r.bad = mdl_bad;
            pending_steps.push_back(r);
            mdl_sq_sum = '0;
            mdl_bad = '0;
        end
    endtask

    // Offers one bond at the falling edge and holds it until it is accepted.
    // The valid stays high after acceptance so that items can follow back to back;
    // the task drops it while the sender idles, and the caller drops it when sending stops.
    task automatic send_bond(input bond_t b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tlast  <= b.last;
        s_tdata  <= {4'b0, b.v[5], b.v[4], b.v[3], b.v[2], b.v[1], b.v[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_bond(b);
        @(negedge aclk);
    endtask

    function automatic bond_t make_bond(input int ox, oy, oz, nx, ny, nz, input bit lst);
        bond_t b;
        b.v[0] = COMP_W'(ox); b.v[1] = COMP_W'(oy); b.v[2] = COMP_W'(oz);
        b.v[3] = COMP_W'(nx); b.v[4] = COMP_W'(ny); b.v[5] = COMP_W'(nz);
        b.last = lst;
        return b;
    endfunction

    // Random component: mostly full range, sometimes the extremes or small values.
    function automatic logic signed [COMP_W-1:0] rand_comp();
        case ($urandom_range(9))
            0: return -131072;
            1: return 131071;
            2: return $signed(COMP_W'($urandom_range(7))) - 3;
            default: return COMP_W'($urandom);
        endcase
    endfunction

    function automatic bond_t rand_bond(input bit lst);
        bond_t b;
        for (int i = 0; i < 6; i++) b.v[i] = rand_comp();
        case ($urandom_range(19))
            0: for (int i = 0; i < 3; i++) b.v[i+3] = b.v[i];
            1: for (int i = 0; i < 3; i++) b.v[i] = 0;
            2: for (int i = 0; i < 3; i++) b.v[i+3] = 0;
            // Nearly antiparallel and nearly parallel pairs.
            3: for (int i = 0; i < 3; i++) b.v[i+3] = -b.v[i] + $signed(2'($urandom));
            4: for (int i = 0; i < 3; i++) b.v[i+3] = b.v[i] + $signed(2'($urandom));
            default: ;
        endcase
        b.last = lst;
        return b;
    endfunction

    // Directed table; the expected summary is typed in where it is obvious, else -1.
    typedef struct {
        bond_t  b;
        longint exp_inc;
        longint exp_bad;
    } dir_row_t;

    // Receiver: random stalls, a long hold-off on request, checks at the rising edge.
    always @(negedge aclk) begin
        if (hold_recv) m_tready <= 1'b0;
        else m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge aclk) begin
        step_sum_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_steps.size() == 0) begin
                $error("step summary with none expected: %h", m_tdata);
                errors++;
            end else begin
                e = pending_steps.pop_front();
                if (m_tdata[20:0] !== e.inc) begin
                    $error("step_increment expected %0d actual %0d", e.inc, m_tdata[20:0]);
                    errors++;
                end
                if (m_tdata[60:21] !== e.total) begin
                    $error("total_length expected %0d actual %0d", e.total, m_tdata[60:21]);
                    errors++;
                end
                if (m_tdata[71:61] !== e.bad) begin
                    $error("bad_bonds expected %0d actual %0d", e.bad, m_tdata[71:61]);
                    errors++;
                end
            end
        end
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #(20 * 3000000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        int n;
        mdl_sq_sum = '0;
        mdl_total = '0;
        mdl_bad = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Equal vectors, zero vectors, right angles, extremes, clamp and opposite directions.
        rows.push_back('{make_bond(0, 0, 0, 0, 0, 0, 1), 0, 0});
        rows.push_back('{make_bond(16384, 0, 0, 16384, 0, 0, 1), 0, 0});
        rows.push_back('{make_bond(0, 0, 0, 16384, 0, 0, 1), 0, 1});
        rows.push_back('{make_bond(5, -7, 9, 0, 0, 0, 0), -1, -1});
        rows.push_back('{make_bond(0, 0, 0, -1, 0, 0, 1), 0, 2});
        rows.push_back('{make_bond(16384, 0, 0, 0, 16384, 0, 1), -1, -1});
        rows.push_back('{make_bond(16384, 0, 0, -16384, 0, 0, 1), -1, -1});
        rows.push_back('{make_bond(131071, 131071, 131071, -131072, -131072, -131072, 1),
                         -1, -1});
        rows.push_back('{make_bond(-131072, 0, 0, 131071, 0, 0, 1), -1, -1});
        rows.push_back('{make_bond(131071, 131071, 131071, 131070, 131071, 131071, 1),
                         -1, -1});
        rows.push_back('{make_bond(1, 0, 0, 0, 0, -1, 0), -1, -1});
        rows.push_back('{make_bond(-131072, -131072, -131072, 131071, -131072, 1, 0),
                         -1, -1});
        rows.push_back('{make_bond(3, 4, 0, 4, -3, 0, 1), -1, -1});
        rows.push_back('{make_bond(7, 7, 7, 7, 7, 7, 1), 0, 0});

        foreach (rows[i]) begin
            row = rows[i];
            send_bond(row.b);
            if (row.b.last && row.exp_inc >= 0) begin
                // The model agrees with the obvious value by construction; check both.
                if (pending_steps[$].inc != row.exp_inc ||
                    pending_steps[$].bad != row.exp_bad) begin
                    $error("directed row %0d: inc expected %0d model %0d", i, row.exp_inc,
                           pending_steps[$].inc);
                    errors++;
                end
            end
        end

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 14 : 87) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 14 : 87) : 0;
            n = 0;
            while (n < 340) begin
                int len;
                // Mostly short steps, now and then a long one.
                len = ($urandom_range(15) == 0) ? $urandom_range(80, 20) : $urandom_range(6, 1);
                for (int k = 0; k < len; k++) begin
                    send_bond(rand_bond(k == len - 1));
                    n++;
                end
                if (ph == 0 && n < 40) begin
                    // Hold the receiver off while single-bond steps keep arriving.
                    hold_recv = 1'b1;
                    fork
                        begin
                            repeat (3000) @(posedge aclk);
                            hold_recv = 1'b0;
                        end
                        begin
                            for (int k = 0; k < 6; k++) send_bond(rand_bond(1));
                            s_tvalid <= 1'b0;
                        end
                    join
                    @(negedge aclk);
                    n += 6;
                end
            end
        end

        // A step of many opposite vectors drives the step increment into saturation.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 110; k++)
            send_bond(make_bond(131071, 0, 0, -131072, 0, 0, k == 109));
        s_tvalid <= 1'b0;

        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
